/* sv/dovm_pkg.sv */
// dovm_pkg: shared types, codes, defaults and constant tables of the drawbar organ voice mixer
// no dependencies; used by the controller, datapath, top level and checker
package dovm_pkg;

	// default sizes
	localparam int KEY_COUNT_DEF     = 61;
	localparam int WAVE_COUNT_DEF    = 91;
	localparam int DRAWBAR_COUNT_DEF = 9;
	localparam int WAVE_DEPTH_DEF    = 16384;
	localparam int SAMPLE_BITS_DEF   = 16;

	// item operations
	typedef enum logic [1:0] {
		OP_MIDI     = 2'd0,
		OP_TICK     = 2'd1,
		OP_WAVE_WR  = 2'd2,
		OP_WAVE_LEN = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic CFG_ATTACK = 1'b0;
	localparam logic CFG_FLOOR  = 1'b1;

	// midi codes
	localparam logic [7:0] ST_NOTE_ON  = 8'h90;
	localparam logic [7:0] ST_NOTE_OFF = 8'h80;
	localparam logic [7:0] ST_CTRL     = 8'hB0;
	localparam logic [7:0] NOTE_BASE   = 8'd36;
	localparam logic [6:0] CC_FIRST    = 7'd16;
	localparam logic [6:0] CC_LAST     = 7'd24;

	// levels
	localparam logic [15:0] UNITY       = 16'h8000;
	localparam logic [6:0]  ATTACK_RST  = 7'd3;
	localparam logic [15:0] FLOOR_RST   = 16'd2920;

	// octave foldback, x/12 as (x*171)>>11 for x below 256
	localparam logic [7:0]  OCTAVE      = 8'd12;
	localparam logic [15:0] OCT_RECIP   = 16'd171;
	localparam int          OCT_RSH     = 11;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic acc_clear;
		logic env_read;
		logic term_issue;
		logic env_write;
		logic pass_issue;
		logic load_out;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic key_active;
		logic pipe_busy;
		logic out_free;
	} stat_t;

	// harmonic offset of each drawbar in semitones
	function automatic logic [5:0] harm_offset(input logic [3:0] d);
		logic [5:0] r;
		case (d)
			4'd0:    r = 6'd0;
			4'd1:    r = 6'd19;
			4'd2:    r = 6'd12;
			4'd3:    r = 6'd24;
			4'd4:    r = 6'd31;
			4'd5:    r = 6'd36;
			4'd6:    r = 6'd40;
			4'd7:    r = 6'd43;
			4'd8:    r = 6'd48;
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	// Q1.15 drawbar gain per step
	function automatic logic [15:0] step_gain(input logic [3:0] i);
		logic [15:0] r;
		case (i)
			4'd0:    r = 16'd0;
			4'd1:    r = 16'd2920;
			4'd2:    r = 16'd4096;
			4'd3:    r = 16'd5833;
			4'd4:    r = 16'd8192;
			4'd5:    r = 16'd11633;
			4'd6:    r = 16'd16384;
			4'd7:    r = 16'd23200;
			4'd8:    r = 16'd32768;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	// lower and upper octave foldback of a wave number
	function automatic logic [7:0] fold_wave(input logic [7:0] w, input logic [7:0] wc);
		logic [7:0]  x;
		logic [15:0] q;
		logic [7:0]  n;
		logic [7:0]  r;
		x = w - wc;
		q = 16'(x) * OCT_RECIP;
		n = 8'(q >> OCT_RSH) + 8'd1;
		if (w < OCTAVE)
			r = w + OCTAVE;
		else if (w >= wc)
			r = w - 8'(n * OCTAVE);
		else
			r = w;
		return r;
	endfunction

endpackage

/* sv/dovm_ctrl.sv */
// dovm_ctrl: sequencer of the voice mixer; walks keys, drawbars and waves for a tick
// depends on dovm_pkg for commands, status and operation codes
module dovm_ctrl import dovm_pkg::*; #(
	parameter int KEY_COUNT     = KEY_COUNT_DEF,
	parameter int WAVE_COUNT    = WAVE_COUNT_DEF,
	parameter int DRAWBAR_COUNT = DRAWBAR_COUNT_DEF,
	localparam int KW = $clog2(KEY_COUNT),
	localparam int WW = $clog2(WAVE_COUNT),
	localparam int DW = (DRAWBAR_COUNT > 1) ? $clog2(DRAWBAR_COUNT) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  op_t           op,
	input  stat_t         stat,
	output cmd_t          cmd,
	output logic [KW-1:0] key_idx,
	output logic [DW-1:0] db_idx,
	output logic [WW-1:0] wave_idx
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ISSUE,
		S_DRAIN,
		S_PASS,
		S_RESULT
	} state_t;

	localparam logic [KW-1:0] KEY_LAST  = KW'(KEY_COUNT - 1);
	localparam logic [WW-1:0] WAVE_LAST = WW'(WAVE_COUNT - 1);
	localparam logic [DW-1:0] DB_LAST   = DW'(DRAWBAR_COUNT - 1);

	state_t        state_q;
	logic [KW-1:0] key_q;
	logic [DW-1:0] db_q;
	logic [WW-1:0] wave_q;

	assign in_ready = (state_q == S_IDLE);
	assign key_idx  = key_q;
	assign db_idx   = db_q;
	assign wave_idx = wave_q;

	// commands decoded from state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.accept    = in_valid;
				cmd.acc_clear = in_valid && (op == OP_TICK);
			end
			S_SCAN:   cmd.env_read = 1'b1;
			S_ISSUE: begin
				cmd.term_issue = 1'b1;
				cmd.env_write  = (db_q == DB_LAST);
			end
			S_PASS:   cmd.pass_issue = 1'b1;
			S_RESULT: cmd.load_out = stat.out_free;
			default:  cmd = '0;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			key_q   <= '0;
			db_q    <= '0;
			wave_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && (op == OP_TICK)) begin
						state_q <= S_SCAN;
						key_q   <= '0;
					end
				end
				S_SCAN: begin
					if (stat.key_active) begin
						state_q <= S_ISSUE;
						db_q    <= '0;
					end else if (key_q == KEY_LAST) begin
						state_q <= S_DRAIN;
					end else begin
						key_q <= key_q + 1'b1;
					end
				end
				S_ISSUE: begin
					if (db_q == DB_LAST) begin
						if (key_q == KEY_LAST) begin
							state_q <= S_DRAIN;
						end else begin
							key_q   <= key_q + 1'b1;
							state_q <= S_SCAN;
						end
					end else begin
						db_q <= db_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!stat.pipe_busy) begin
						state_q <= S_PASS;
						wave_q  <= '0;
					end
				end
				S_PASS: begin
					if (wave_q == WAVE_LAST)
						state_q <= S_RESULT;
					else
						wave_q <= wave_q + 1'b1;
				end
				S_RESULT: begin
					if (stat.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* sv/dovm_datapath.sv */
// dovm_datapath: key, envelope, gain, phase and wave stores, term pipeline and output register
// depends on dovm_pkg for commands, status, codes and tables
module dovm_datapath import dovm_pkg::*; #(
	parameter int KEY_COUNT     = KEY_COUNT_DEF,
	parameter int WAVE_COUNT    = WAVE_COUNT_DEF,
	parameter int DRAWBAR_COUNT = DRAWBAR_COUNT_DEF,
	parameter int WAVE_DEPTH    = WAVE_DEPTH_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	localparam int KW = $clog2(KEY_COUNT),
	localparam int WW = $clog2(WAVE_COUNT),
	localparam int DW = (DRAWBAR_COUNT > 1) ? $clog2(DRAWBAR_COUNT) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  op_t                op,
	input  logic [7:0]         status_byte,
	input  logic [6:0]         data_one,
	input  logic [6:0]         data_two,
	input  logic [6:0]         wave_select,
	input  logic [13:0]        sample_address,
	input  logic signed [15:0] sample_value,
	input  logic [14:0]        wave_length,
	input  cmd_t               cmd,
	input  logic [KW-1:0]      key_idx,
	input  logic [DW-1:0]      db_idx,
	input  logic [WW-1:0]      wave_idx,
	output stat_t              stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [19:0] audio_out
);

	localparam int PW     = (WAVE_DEPTH > 1) ? $clog2(WAVE_DEPTH) : 1;
	localparam int LW     = $clog2(WAVE_DEPTH + 1);
	localparam int AW     = $clog2(WAVE_COUNT * WAVE_DEPTH);
	localparam int TERM_W = 18 + SAMPLE_BITS;
	localparam int ACC_RAW = TERM_W + $clog2(KEY_COUNT * DRAWBAR_COUNT) + 1;
	localparam int ACC_W  = (ACC_RAW > 36) ? ACC_RAW : 36;
	localparam logic [LW-1:0] DEPTH_LEN = LW'(WAVE_DEPTH);
	localparam logic signed [24:0] SMP_HI = 25'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [24:0] SMP_LO = -SMP_HI - 25'sd1;
	localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(524287);
	localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

	// configuration
	logic [6:0]  attack_q;
	logic [15:0] floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q <= ATTACK_RST;
			floor_q  <= FLOOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ATTACK: attack_q <= cfg_data[6:0];
				CFG_FLOOR:  floor_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// request decode
	logic          do_midi, do_wr, do_len;
	logic [7:0]    note_k;
	logic          note_ok;
	logic [KW-1:0] note_idx;
	logic [6:0]    cc_db;
	logic          cc_ok;
	logic [7:0]    step_sum;
	logic          wsel_ok;
	logic          addr_ok;
	logic [WW-1:0] wsel;
	logic [LW-1:0] len_clip;
	logic signed [24:0] sv_wide;
	logic signed [24:0] sv_clip;

	assign do_midi  = cmd.accept && (op == OP_MIDI);
	assign wsel_ok  = ({1'b0, wave_select} < 8'(WAVE_COUNT));
	assign do_wr    = cmd.accept && (op == OP_WAVE_WR) && wsel_ok && addr_ok;
	assign do_len   = cmd.accept && (op == OP_WAVE_LEN) && wsel_ok;
	assign wsel     = WW'(wave_select);
	assign note_k   = {1'b0, data_one} - NOTE_BASE;
	assign note_ok  = ({1'b0, data_one} >= NOTE_BASE) && (note_k < 8'(KEY_COUNT));
	assign note_idx = KW'(note_k);
	assign cc_db    = data_one - CC_FIRST;
	assign cc_ok    = (data_one >= CC_FIRST) && (data_one <= CC_LAST)
		&& ({1'b0, cc_db} < 8'(DRAWBAR_COUNT));
	assign step_sum = {1'b0, data_two} + 8'd8;
	assign addr_ok  = (17'(sample_address) < 17'(WAVE_DEPTH));
	assign sv_wide  = 25'(sample_value);

	always_comb begin
		if (sv_wide > SMP_HI)
			sv_clip = SMP_HI;
		else if (sv_wide < SMP_LO)
			sv_clip = SMP_LO;
		else
			sv_clip = sv_wide;
		if (wave_length == 15'd0)
			len_clip = LW'(1);
		else if (17'(wave_length) > 17'(WAVE_DEPTH))
			len_clip = DEPTH_LEN;
		else
			len_clip = LW'(wave_length);
	end

	// key activity and drawbar gains
	logic [KEY_COUNT-1:0] key_act_q;
	logic [15:0]          gain_q [DRAWBAR_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_act_q <= '0;
			for (int d = 0; d < DRAWBAR_COUNT; d++)
				gain_q[d] <= (d < 3) ? UNITY : 16'd0;
		end else if (do_midi) begin
			if (note_ok && (status_byte == ST_NOTE_ON))
				key_act_q[note_idx] <= 1'b1;
			else if (note_ok && (status_byte == ST_NOTE_OFF))
				key_act_q[note_idx] <= 1'b0;
			else if (cc_ok && (status_byte == ST_CTRL))
				gain_q[DW'(cc_db)] <= step_gain(step_sum[7:4]);
		end
	end

	assign stat.key_active = key_act_q[key_idx];

	// envelope memory
	logic [15:0] env_mem [KEY_COUNT];
	logic [15:0] env_rd_q;
	logic [15:0] env_next;
	logic [15:0] flr;
	logic [22:0] grown;

	assign flr   = (floor_q > UNITY) ? UNITY : floor_q;
	assign grown = 23'(env_rd_q) * 23'(attack_q);

	always_comb begin
		if (env_rd_q == UNITY)
			env_next = env_rd_q;
		else if (env_rd_q < flr)
			env_next = flr;
		else if (grown > 23'(UNITY))
			env_next = UNITY;
		else
			env_next = grown[15:0];
	end

	always_ff @(posedge clk) begin
		if (do_midi && note_ok && (status_byte == ST_NOTE_ON) && !key_act_q[note_idx])
			env_mem[note_idx] <= 16'd0;
		else if (cmd.env_write)
			env_mem[key_idx] <= env_next;
		if (cmd.env_read)
			env_rd_q <= env_mem[key_idx];
	end

	// harmonic wave choice with foldback
	logic [7:0]    k_plus;
	logic [WW-1:0] w_fold;

	assign k_plus = 8'(key_idx) + {2'b00, harm_offset(4'(db_idx))};
	assign w_fold = WW'(fold_wave(k_plus, 8'(WAVE_COUNT)));

	// phase memory with valid bits, length memory
	logic [PW-1:0]         phase_mem [WAVE_COUNT];
	logic [WAVE_COUNT-1:0] phase_vld_q;
	logic [LW-1:0]         len_mem [WAVE_COUNT];
	logic [PW-1:0]         ph_rd_q;
	logic                  ph_vld_rd_q;
	logic [LW-1:0]         len_rd_q;
	logic [WW-1:0]         ph_rd_addr;
	logic [PW-1:0]         ph_cur;
	logic                  pass_s1;
	logic [WW-1:0]         pw_s1;
	logic [LW-1:0]         ph_inc;
	logic [PW-1:0]         ph_new;

	assign ph_rd_addr = cmd.term_issue ? w_fold : wave_idx;
	assign ph_cur     = ph_vld_rd_q ? ph_rd_q : '0;
	assign ph_inc     = LW'(ph_cur) + 1'b1;
	assign ph_new     = (ph_inc >= len_rd_q) ? '0 : PW'(ph_inc);

	always_ff @(posedge clk) begin
		if (do_len)
			phase_mem[wsel] <= '0;
		else if (pass_s1)
			phase_mem[pw_s1] <= ph_new;
		if (do_len)
			len_mem[wsel] <= len_clip;
		ph_rd_q  <= phase_mem[ph_rd_addr];
		len_rd_q <= len_mem[wave_idx];
		pw_s1    <= wave_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_vld_q <= '0;
			ph_vld_rd_q <= 1'b0;
			pass_s1     <= 1'b0;
		end else begin
			if (do_len)
				phase_vld_q[wsel] <= 1'b1;
			else if (pass_s1)
				phase_vld_q[pw_s1] <= 1'b1;
			ph_vld_rd_q <= phase_vld_q[ph_rd_addr];
			pass_s1     <= cmd.pass_issue;
		end
	end

	// wave sample memory
	logic [SAMPLE_BITS-1:0] wave_mem [WAVE_COUNT * WAVE_DEPTH];
	logic [AW-1:0]          wr_addr;
	logic [AW-1:0]          rd_addr;
	logic [WW-1:0]          w_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s2;

	assign wr_addr = AW'(wsel) * AW'(WAVE_DEPTH) + AW'(sample_address);
	assign rd_addr = AW'(w_s1) * AW'(WAVE_DEPTH) + AW'(ph_cur);

	always_ff @(posedge clk) begin
		if (do_wr)
			wave_mem[wr_addr] <= SAMPLE_BITS'(sv_clip);
		sample_s2 <= wave_mem[rd_addr];
	end

	// term pipeline: gain product, sample read, term product, accumulate
	logic        vld_s1, vld_s2, vld_s3;
	logic [31:0] prod_s1;
	logic [16:0] eg_s2;
	logic signed [TERM_W-1:0] term_s3;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= 32'(env_rd_q) * 32'(gain_q[db_idx]);
		w_s1    <= w_fold;
		eg_s2   <= 17'((prod_s1 + 32'd16384) >> 15);
		term_s3 <= TERM_W'($signed({1'b0, eg_s2})) * TERM_W'(sample_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= cmd.term_issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (cmd.acc_clear)
				acc_q <= '0;
			else if (vld_s3)
				acc_q <= acc_q + ACC_W'(term_s3);
		end
	end

	assign stat.pipe_busy = vld_s1 || vld_s2 || vld_s3;

	// scale to Q5.15 with floor, saturate, output register
	logic signed [ACC_W-1:0] acc_sh;
	logic signed [19:0]      audio_sat;
	logic                    out_valid_q;
	logic signed [19:0]      audio_q;

	assign acc_sh = acc_q >>> 15;

	always_comb begin
		if (acc_sh > OUT_MAX)
			audio_sat = 20'sh7FFFF;
		else if (acc_sh < OUT_MIN)
			audio_sat = 20'sh80000;
		else
			audio_sat = 20'(acc_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			audio_q <= audio_sat;
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign audio_out     = audio_q;

endmodule

/* sv/drawbar_organ_voice_mixer.sv */
// drawbar_organ_voice_mixer: top level joining sequencer and datapath
// depends on dovm_pkg, dovm_ctrl and dovm_datapath
//
//  channel   handshake             payload
//  input     in_valid / in_ready   operation, status_byte, data_one, data_two,
//                                  wave_select, sample_address, sample_value, wave_length
//  output    out_valid / out_ready audio_out
//  config    cfg_we                cfg_index, cfg_data
//
// midi, sample write and length write requests do not make the block busy.
// a tick reads each key's envelope in turn, passes each term of an active key, one term
// per cycle, through the shared multiply pipeline, and passes each wave, one wave per
// cycle, through the phase memory port. reset clears keys, phase valid bits and registers,
// sets the first three drawbar gains to unity and the rest to zero; wave tables need
// writing first. a pending result holds the next tick in its last state until out_ready;
// while a result waits and no tick is held there, new requests are still taken.
module drawbar_organ_voice_mixer import dovm_pkg::*; #(
	parameter int KEY_COUNT     = KEY_COUNT_DEF,
	parameter int WAVE_COUNT    = WAVE_COUNT_DEF,
	parameter int DRAWBAR_COUNT = DRAWBAR_COUNT_DEF,
	parameter int WAVE_DEPTH    = WAVE_DEPTH_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [7:0]         status_byte,
	input  logic [6:0]         data_one,
	input  logic [6:0]         data_two,
	input  logic [6:0]         wave_select,
	input  logic [13:0]        sample_address,
	input  logic signed [15:0] sample_value,
	input  logic [14:0]        wave_length,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [19:0] audio_out
);

	localparam int KW = $clog2(KEY_COUNT);
	localparam int WW = $clog2(WAVE_COUNT);
	localparam int DW = (DRAWBAR_COUNT > 1) ? $clog2(DRAWBAR_COUNT) : 1;

	cmd_t          cmd;
	stat_t         stat;
	op_t           op;
	logic [KW-1:0] key_idx;
	logic [DW-1:0] db_idx;
	logic [WW-1:0] wave_idx;

	assign op = op_t'(operation);

	// sequencer
	dovm_ctrl #(
		.KEY_COUNT(KEY_COUNT),
		.WAVE_COUNT(WAVE_COUNT),
		.DRAWBAR_COUNT(DRAWBAR_COUNT)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.stat(stat),
		.cmd(cmd),
		.key_idx(key_idx),
		.db_idx(db_idx),
		.wave_idx(wave_idx)
	);

	// stores and arithmetic
	dovm_datapath #(
		.KEY_COUNT(KEY_COUNT),
		.WAVE_COUNT(WAVE_COUNT),
		.DRAWBAR_COUNT(DRAWBAR_COUNT),
		.WAVE_DEPTH(WAVE_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.op(op),
		.status_byte(status_byte),
		.data_one(data_one),
		.data_two(data_two),
		.wave_select(wave_select),
		.sample_address(sample_address),
		.sample_value(sample_value),
		.wave_length(wave_length),
		.cmd(cmd),
		.key_idx(key_idx),
		.db_idx(db_idx),
		.wave_idx(wave_idx),
		.stat(stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.audio_out(audio_out)
	);

endmodule

/* sv/dovm_checker.sv */
// dovm_assert: port-level assertions of the voice mixer, bound to the top level
// depends on dovm_pkg for operation codes
module dovm_assert import dovm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         operation,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [19:0] audio_out
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(audio_out))
		else $error("stalled result changed");

	// a non-tick request never makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation != OP_TICK) |=> in_ready)
		else $error("busy after single-cycle request");

	// a tick request always starts a busy period
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_TICK) |=> !in_ready)
		else $error("tick did not start");

	// a new result only comes out of a busy period
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without tick");

endmodule

bind drawbar_organ_voice_mixer dovm_assert u_chk (.*);

/* verif/dovm_checker.sv */
// dovm_checker: watches the request, result and configuration ports of the organ voice mixer,
// predicts each mixed sample and compares it with the block's output
// depends on dovm_pkg
module dovm_checker import dovm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [7:0]         status_byte,
	input  logic [6:0]         data_one,
	input  logic [6:0]         data_two,
	input  logic [6:0]         wave_select,
	input  logic [13:0]        sample_address,
	input  logic signed [15:0] sample_value,
	input  logic [14:0]        wave_length,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [19:0] audio_out,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);

	localparam int NKEY  = KEY_COUNT_DEF;
	localparam int NWAVE = WAVE_COUNT_DEF;
	localparam int NBAR  = DRAWBAR_COUNT_DEF;
	localparam int DEPTH = WAVE_DEPTH_DEF;

	// predicted block state
	int unsigned      attack_mul;
	int unsigned      env_floor;
	bit               key_on [NKEY];
	int unsigned      env_lvl [NKEY];
	int unsigned      bar_gain [NBAR];
	shortint          wave_mem [0:NWAVE*DEPTH-1];
	int unsigned      loop_len [NWAVE];
	int unsigned      wave_ph [NWAVE];
	logic signed [19:0] sample_q [$];

	function automatic int unsigned fold(input int unsigned w);
		if (w < 12)
			return w + 12;
		while (w >= NWAVE)
			w -= 12;
		return w;
	endfunction

	function automatic int unsigned gain_code(input int unsigned i);
		case (i)
			1: return 2920;
			2: return 4096;
			3: return 5833;
			4: return 8192;
			5: return 11633;
			6: return 16384;
			7: return 23200;
			8: return 32768;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned bar_offset(input int unsigned d);
		case (d)
			1: return 19;
			2: return 12;
			3: return 24;
			4: return 31;
			5: return 36;
			6: return 40;
			7: return 43;
			8: return 48;
			default: return 0;
		endcase
	endfunction

	// one sample: sum all harmonics, then advance envelopes and phases
	function logic signed [19:0] mix_sample();
		longint acc;
		int unsigned w, eg, lvl, flr, grown, p, l;
		acc = 0;
		flr = (env_floor > 32768) ? 32768 : env_floor;
		for (int k = 0; k < NKEY; k++) begin
			if (!key_on[k])
				continue;
			for (int d = 0; d < NBAR; d++) begin
				w = fold(k + bar_offset(d));
				eg = (env_lvl[k] * bar_gain[d] + 16384) >> 15;
				acc += longint'(eg) * longint'(wave_mem[w*DEPTH + wave_ph[w]]);
			end
			lvl = env_lvl[k];
			if (lvl != 32768) begin
				if (lvl < flr) begin
					env_lvl[k] = flr;
				end else begin
					grown = lvl * attack_mul;
					env_lvl[k] = (grown > 32768) ? 32768 : grown;
				end
			end
		end
		for (int i = 0; i < NWAVE; i++) begin
			l = (loop_len[i] == 0) ? 1 : loop_len[i];
			p = wave_ph[i] + 1;
			wave_ph[i] = (p >= l) ? 0 : p;
		end
		acc = acc >>> 15;
		if (acc > 524287)
			acc = 524287;
		if (acc < -524288)
			acc = -524288;
		return 20'(acc);
	endfunction

	// midi request: notes and drawbar controllers
	function void apply_midi(input logic [7:0] st, input int unsigned d1, input int unsigned d2);
		int unsigned k;
		if (st == ST_NOTE_ON || st == ST_NOTE_OFF) begin
			if (d1 < 36 || d1 - 36 >= NKEY)
				return;
			k = d1 - 36;
			if (st == ST_NOTE_ON) begin
				if (!key_on[k]) begin
					key_on[k] = 1;
					env_lvl[k] = 0;
				end
			end else begin
				key_on[k] = 0;
			end
		end else if (st == ST_CTRL) begin
			if (d1 < 16 || d1 > 24 || d1 - 16 >= NBAR)
				return;
			bar_gain[d1 - 16] = gain_code(((d2 + 8) >> 4) & 4'hF);
		end
	endfunction

	// predict on requests and configuration writes, compare on results
	always @(posedge clk or negedge arst_n) begin
		int unsigned l;
		logic signed [19:0] exp_s;
		if (!arst_n) begin
			attack_mul = 3;
			env_floor = 2920;
			for (int k = 0; k < NKEY; k++) begin
				key_on[k] = 0;
				env_lvl[k] = 0;
			end
			for (int d = 0; d < NBAR; d++)
				bar_gain[d] = (d < 3) ? 32768 : 0;
			for (int w = 0; w < NWAVE; w++) begin
				loop_len[w] = 0;
				wave_ph[w] = 0;
			end
			sample_q.delete();
			fail_count = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ATTACK)
					attack_mul = 32'(cfg_data[6:0]);
				else
					env_floor = 32'(cfg_data);
			end
			if (in_valid && in_ready) begin
				case (op_t'(operation))
					OP_MIDI: apply_midi(status_byte, 32'(data_one), 32'(data_two));
					OP_TICK: sample_q.push_back(mix_sample());
					OP_WAVE_WR: begin
						if (wave_select < NWAVE && sample_address < DEPTH)
							wave_mem[wave_select*DEPTH + sample_address] = sample_value;
					end
					OP_WAVE_LEN: begin
						if (wave_select < NWAVE) begin
							l = 32'(wave_length);
							if (l == 0)
								l = 1;
							if (l > DEPTH)
								l = DEPTH;
							loop_len[wave_select] = l;
							wave_ph[wave_select] = 0;
						end
					end
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				checked++;
				if (sample_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: unexpected sample %0d", audio_out);
				end else begin
					exp_s = sample_q.pop_front();
					if (audio_out !== exp_s) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: sample %0d expected %0d got %0d",
								checked, exp_s, audio_out);
					end
				end
			end
			pending = sample_q.size();
		end
	end

endmodule

/* verif/tb_drawbar_organ_voice_mixer.sv */
// tb_drawbar_organ_voice_mixer: drives midi, tick and wave-table requests into the mixer
// with random gaps and output stalls; dovm_checker predicts and compares the samples
// depends on dovm_pkg, drawbar_organ_voice_mixer and dovm_checker
module tb_drawbar_organ_voice_mixer;
	import dovm_pkg::*;

	localparam int NWAVE = WAVE_COUNT_DEF;
	localparam int DEPTH = WAVE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		op_t         op;
		logic [7:0]  st;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic [6:0]  ws;
		logic [13:0] addr;
		logic [15:0] val;
		logic [14:0] len;
	} organ_req_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic               cfg_index = CFG_ATTACK;
	logic [15:0]        cfg_data = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [1:0]         operation = OP_MIDI;
	logic [7:0]         status_byte = 0;
	logic [6:0]         data_one = 0;
	logic [6:0]         data_two = 0;
	logic [6:0]         wave_select = 0;
	logic [13:0]        sample_address = 0;
	logic signed [15:0] sample_value = 0;
	logic [14:0]        wave_length = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [19:0] audio_out;
	int                 fail_count, pending, checked;

	// stimulus-side view of which table entries are written and where each phase points
	bit          written [0:NWAVE*DEPTH-1];
	int unsigned mirror_len [NWAVE];
	int unsigned mirror_ph [NWAVE];
	bit          steady;
	int          n_tick, n_midi, n_load, cycles;

	always #4 clk = ~clk;

	drawbar_organ_voice_mixer uut (.*);

	dovm_checker chk (.*);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(20, 150);
	endfunction

	// output stalls
	always @(posedge clk) begin
		out_ready <= steady ? 1'b1 : (gap_len() == 0);
	end

	task automatic drive_request(input organ_req_t r);
		int unsigned l, p;
		int g;
		in_valid <= 1;
		operation <= r.op;
		status_byte <= r.st;
		data_one <= r.d1;
		data_two <= r.d2;
		wave_select <= r.ws;
		sample_address <= r.addr;
		sample_value <= r.val;
		wave_length <= r.len;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		case (r.op)
			OP_MIDI: n_midi++;
			OP_TICK: begin
				n_tick++;
				for (int w = 0; w < NWAVE; w++) begin
					p = mirror_ph[w] + 1;
					mirror_ph[w] = (p >= mirror_len[w]) ? 0 : p;
				end
			end
			OP_WAVE_WR: begin
				n_load++;
				if (r.ws < NWAVE)
					written[r.ws*DEPTH + r.addr] = 1;
			end
			OP_WAVE_LEN: begin
				n_load++;
				if (r.ws < NWAVE) begin
					l = 32'(r.len);
					if (l == 0)
						l = 1;
					if (l > DEPTH)
						l = DEPTH;
					mirror_len[r.ws] = l;
					mirror_ph[r.ws] = 0;
				end
			end
			default: ;
		endcase
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic organ_req_t blank_req(input op_t op);
		organ_req_t r;
		r = '0;
		r.op = op;
		r.st = 8'($urandom);
		r.d1 = 7'($urandom);
		r.d2 = 7'($urandom);
		r.ws = 7'($urandom);
		r.addr = 14'($urandom);
		r.val = 16'($urandom);
		r.len = 15'($urandom);
		return r;
	endfunction

	// a tick may read any wave at its phase, so fill any unwritten entry first
	task automatic send(input organ_req_t r);
		organ_req_t fill;
		if (r.op == OP_TICK) begin
			for (int w = 0; w < NWAVE; w++) begin
				if (!written[w*DEPTH + mirror_ph[w]]) begin
					fill = blank_req(OP_WAVE_WR);
					fill.ws = 7'(w);
					fill.addr = 14'(mirror_ph[w]);
					drive_request(fill);
				end
			end
		end
		drive_request(r);
	endtask

	task automatic midi(input logic [7:0] st, input logic [6:0] d1, input logic [6:0] d2);
		organ_req_t r;
		r = blank_req(OP_MIDI);
		r.st = st;
		r.d1 = d1;
		r.d2 = d2;
		send(r);
	endtask

	task automatic tick();
		send(blank_req(OP_TICK));
	endtask

	task automatic set_len(input logic [6:0] ws, input logic [14:0] len);
		organ_req_t r;
		r = blank_req(OP_WAVE_LEN);
		r.ws = ws;
		r.len = len;
		send(r);
	endtask

	task automatic write_cfg(input logic idx, input logic [15:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// drain all samples, let the block settle, then change the envelope setup
	task automatic reconfigure(input logic [15:0] att, input logic [15:0] flr);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		write_cfg(CFG_ATTACK, att);
		write_cfg(CFG_FLOOR, flr);
	endtask

	// random mix: mostly well-formed midi and ticks, some table traffic and noise
	task automatic random_request();
		organ_req_t r;
		int c;
		c = $urandom_range(0, 99);
		if (c < 30) begin
			tick();
		end else if (c < 50) begin
			midi(ST_NOTE_ON, 7'($urandom_range(36, 96)), 7'($urandom));
		end else if (c < 62) begin
			midi(ST_NOTE_OFF, 7'($urandom_range(36, 96)), 7'($urandom));
		end else if (c < 72) begin
			midi(ST_CTRL, 7'($urandom_range(16, 24)), 7'($urandom));
		end else if (c < 82) begin
			r = blank_req(OP_WAVE_WR);
			if ($urandom_range(0, 3) != 0)
				r.ws = 7'($urandom_range(0, NWAVE - 1));
			send(r);
		end else if (c < 88) begin
			r = blank_req(OP_WAVE_LEN);
			if ($urandom_range(0, 3) != 0)
				r.len = 15'($urandom_range(1, 6));
			send(r);
		end else begin
			r = blank_req(OP_MIDI);
			if ($urandom_range(0, 1))
				r.st = $urandom_range(0, 1) ? ST_NOTE_ON : ST_CTRL;
			send(r);
		end
	endtask

	initial begin
		organ_req_t r;
		cycles = 0;
		steady = 0;
		n_tick = 0;
		n_midi = 0;
		n_load = 0;
		for (int w = 0; w < NWAVE; w++) begin
			mirror_len[w] = 1;
			mirror_ph[w] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// every wave gets a short loop and its samples, extremes included
		for (int w = 0; w < NWAVE; w++) begin
			set_len(7'(w), 15'($urandom_range(1, 4)));
			for (int a = 0; a < int'(mirror_len[w]); a++) begin
				r = blank_req(OP_WAVE_WR);
				r.ws = 7'(w);
				r.addr = 14'(a);
				if (w == 0)
					r.val = 16'h8000;
				else if (w == 1)
					r.val = 16'h7FFF;
				send(r);
			end
		end

		// directed: key and controller range edges, odd statuses, table edges
		tick();
		midi(ST_NOTE_ON, 7'd36, 7'd0);
		midi(ST_NOTE_ON, 7'd96, 7'd127);
		midi(ST_NOTE_ON, 7'd35, 7'd64);
		midi(ST_NOTE_ON, 7'd97, 7'd64);
		midi(ST_NOTE_OFF, 7'd127, 7'd0);
		midi(ST_CTRL, 7'd16, 7'd0);
		midi(ST_CTRL, 7'd24, 7'd127);
		midi(ST_CTRL, 7'd25, 7'd127);
		midi(ST_CTRL, 7'd15, 7'd127);
		midi(8'hFF, 7'd60, 7'd60);
		tick();
		midi(ST_NOTE_ON, 7'd36, 7'd100);
		midi(ST_NOTE_OFF, 7'd50, 7'd0);
		tick();
		midi(ST_NOTE_OFF, 7'd96, 7'd0);
		r = blank_req(OP_WAVE_WR);
		r.ws = 7'd127;
		send(r);
		set_len(7'd127, 15'd3);
		r = blank_req(OP_WAVE_WR);
		r.ws = 7'd5;
		r.addr = 14'h3FFF;
		send(r);
		set_len(7'd20, 15'd0);
		set_len(7'd30, 15'h7FFF);
		set_len(7'd40, 15'd16384);
		tick();
		tick();

		// sender waits for every sample before going on
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);

		// random phases over several envelope setups, extremes included
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: reconfigure(16'd1, 16'd0);
				1: reconfigure(16'd64, 16'd32768);
				2: reconfigure(16'hFF80, 16'hFFFF);
				3: reconfigure(16'h007F, 16'd1);
				default: reconfigure(16'($urandom_range(1, 64)),
					16'($urandom_range(0, 32768)));
			endcase
			steady = (ph == 2);
			for (int i = 0; i < 44; i++)
				random_request();
			steady = 0;
		end

		// drain and settle
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);

		$display("covered %0d ticks, %0d midi events and %0d table loads; %0d samples checked",
			n_tick, n_midi, n_load, checked);
		$display("five envelope setups, random gaps and output stalls");
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
